[hdl/iba_pkg.sv]
`default_nettype none

package iba_pkg;

    // default geometry
    localparam int DISK_BLOCKS_DEF  = 128;
    localparam int INODE_COUNT_DEF  = 32;
    localparam int DIRECT_SLOTS_DEF = 10;

    // result status codes
    typedef logic [2:0] status_t;
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_NOSPACE  = 3'd1;
    localparam status_t ST_EXISTS   = 3'd2;
    localparam status_t ST_NOINODE  = 3'd3;
    localparam status_t ST_NOTFOUND = 3'd4;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan_start;
        logic    scan_step;
        logic    pick;
        logic    size_lat;
        logic    prep;
        logic    alloc_step;
        logic    free_step;
        logic    res_write;
        logic    commit_ins;
        logic    commit_del;
        status_t res_code;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic func_del;
        logic n_over;
        logic need_over;
        logic hit;
        logic free_found;
        logic scan_done;
        logic alloc_done;
        logic free_done;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

[hdl/iba_ram.sv]
`default_nettype none

module iba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/iba_ctrl.sv]
`default_nettype none

module iba_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_tvalid,
    output logic               in_tready,
    input  wire iba_pkg::stat_t stat,
    output iba_pkg::cmd_t      cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_DECIDE   = 4'd3;
    localparam logic [3:0] S_SIZE_RD  = 4'd4;
    localparam logic [3:0] S_SIZE_LAT = 4'd5;
    localparam logic [3:0] S_PREP     = 4'd6;
    localparam logic [3:0] S_ALLOC    = 4'd7;
    localparam logic [3:0] S_FREE     = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    logic [3:0]       state_reg, state_next;
    iba_pkg::status_t code_reg, code_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        code_next    = code_reg;
        cmd          = '0;
        cmd.res_code = code_reg;
        in_tready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_tready = 1'b1;
                if (in_tvalid)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.func_del && stat.n_over)
                begin
                    code_next  = iba_pkg::ST_NOSPACE;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                code_next = iba_pkg::ST_OK;
                if (stat.func_del)
                begin
                    if (!stat.hit)
                    begin
                        code_next  = iba_pkg::ST_NOTFOUND;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.pick   = 1'b1;
                        state_next = S_SIZE_RD;
                    end
                end
                else if (stat.hit)
                begin
                    code_next  = iba_pkg::ST_EXISTS;
                    state_next = S_FIN;
                end
                else if (!stat.free_found)
                begin
                    code_next  = iba_pkg::ST_NOINODE;
                    state_next = S_FIN;
                end
                else if (stat.need_over)
                begin
                    code_next  = iba_pkg::ST_NOSPACE;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.pick   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_SIZE_RD:
            begin
                state_next = S_SIZE_LAT;
            end
            S_SIZE_LAT:
            begin
                cmd.size_lat = 1'b1;
                state_next   = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = stat.func_del ? S_FREE : S_ALLOC;
            end
            S_ALLOC:
            begin
                cmd.alloc_step = 1'b1;
                if (stat.alloc_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FREE:
            begin
                cmd.free_step = 1'b1;
                if (stat.free_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.res_write  = 1'b1;
                    cmd.commit_ins = (code_reg == iba_pkg::ST_OK) && !stat.func_del;
                    cmd.commit_del = (code_reg == iba_pkg::ST_OK) && stat.func_del;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= iba_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

`default_nettype wire

[hdl/iba_dpath.sv]
`default_nettype none

module iba_dpath #(
    parameter int DISK_BLOCKS  = iba_pkg::DISK_BLOCKS_DEF,
    parameter int INODE_COUNT  = iba_pkg::INODE_COUNT_DEF,
    parameter int DIRECT_SLOTS = iba_pkg::DIRECT_SLOTS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire iba_pkg::cmd_t cmd,
    output iba_pkg::stat_t     stat,
    input  wire logic          in_func,
    input  wire logic [63:0]   in_key,
    input  wire logic [7:0]    in_count,
    input  wire logic          out_tready,
    output logic               out_tvalid,
    output logic [23:0]        out_data
);

    localparam int IW  = $clog2(INODE_COUNT);
    localparam int SW  = $clog2(INODE_COUNT + 1);
    localparam int BW  = $clog2(DISK_BLOCKS);
    localparam int BCW = $clog2(DISK_BLOCKS + 1);
    localparam int CW  = $clog2(DISK_BLOCKS + 2);
    localparam int DAW = $clog2(INODE_COUNT * DIRECT_SLOTS);
    localparam int LAW = $clog2(INODE_COUNT * DISK_BLOCKS);

    localparam logic [1:0] SRC_DIR  = 2'd0;
    localparam logic [1:0] SRC_PTR  = 2'd1;
    localparam logic [1:0] SRC_LIST = 2'd2;

    // request and file state
    logic                   func_reg;
    logic [63:0]            key_reg;
    logic [7:0]             n_reg;
    logic [BCW-1:0]         free_reg;
    logic [DISK_BLOCKS-1:0] used_reg;
    logic [INODE_COUNT-1:0] valid_reg;

    // inode scan
    logic [SW-1:0] scan_cnt_reg;
    logic          cmp_v_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          ff_reg;
    logic [IW-1:0] ff_idx_reg;
    logic [IW-1:0] slot_reg;

    // block walk
    logic [CW-1:0]  ndir_reg;
    logic [CW-1:0]  total_reg;
    logic           has_ind_reg;
    logic [CW-1:0]  k_reg;
    logic [CW-1:0]  cnt_reg;
    logic [BCW-1:0] b_reg;
    logic [DAW-1:0] dir_base_reg;
    logic [LAW-1:0] list_base_reg;
    logic           rd_v_reg;
    logic [1:0]     src_reg;

    // result word
    logic             out_v_reg;
    iba_pkg::status_t o_status_reg;
    logic [4:0]       o_ino_reg;
    logic [7:0]       o_chg_reg;
    logic [7:0]       o_free_reg;

    logic [63:0]    key_rd;
    logic [7:0]     size_rd;
    logic [BW-1:0]  dir_rd;
    logic [BW-1:0]  ptr_rd;
    logic [BW-1:0]  list_rd;

    logic           has_ind_c;
    logic [1:0]     k_src;
    logic [DAW-1:0] dir_addr;
    logic [LAW-1:0] list_addr;
    logic [BW-1:0]  b_idx;
    logic           b_free;
    logic           alloc_done;
    logic           alloc_take;
    logic           free_issue;
    logic [BW-1:0]  rel_blk;
    logic           rel_ok;
    logic           scan_issue;
    logic           key_match;
    logic [BCW-1:0] free_ins;
    logic [BCW:0]   free_sum;
    logic [BCW-1:0] free_del;
    logic [BCW-1:0] free_res;
    logic           res_ok;

    // request checks
    assign has_ind_c = 32'(n_reg) > DIRECT_SLOTS;

    // which pointer store the walk index maps to
    always_comb
    begin
        if (k_reg < ndir_reg)
        begin
            k_src = SRC_DIR;
        end
        else if (has_ind_reg && k_reg == ndir_reg)
        begin
            k_src = SRC_PTR;
        end
        else
        begin
            k_src = SRC_LIST;
        end
    end

    assign dir_addr  = dir_base_reg + DAW'(k_reg);
    assign list_addr = list_base_reg + LAW'(k_reg) - LAW'(ndir_reg) - LAW'(1);

    // allocation walk over the block map, one block a cycle
    assign b_idx      = b_reg[BW-1:0];
    assign b_free     = (32'(b_reg) < DISK_BLOCKS) && !used_reg[b_idx];
    assign alloc_done = (k_reg == total_reg) || (32'(b_reg) >= DISK_BLOCKS);
    assign alloc_take = cmd.alloc_step && !alloc_done && b_free;

    // release walk: read pointer, clear block in the next cycle
    assign free_issue = cmd.free_step && (k_reg != total_reg);
    always_comb
    begin
        case (src_reg)
            SRC_DIR: rel_blk = dir_rd;
            SRC_PTR: rel_blk = ptr_rd;
            default: rel_blk = list_rd;
        endcase
    end
    assign rel_ok = rd_v_reg && (32'(rel_blk) < DISK_BLOCKS) && used_reg[rel_blk];

    // key scan
    assign scan_issue = cmd.scan_step && (32'(scan_cnt_reg) < INODE_COUNT);
    assign key_match  = valid_reg[cmp_idx_reg] && (key_rd == key_reg);

    // free count after commit
    assign free_ins = free_reg - BCW'(cnt_reg);
    assign free_sum = (BCW + 1)'(free_reg) + (BCW + 1)'(cnt_reg);
    assign free_del = (32'(free_sum) > DISK_BLOCKS) ? BCW'(DISK_BLOCKS) : free_sum[BCW-1:0];
    always_comb
    begin
        if (cmd.commit_ins)
        begin
            free_res = free_ins;
        end
        else if (cmd.commit_del)
        begin
            free_res = free_del;
        end
        else
        begin
            free_res = free_reg;
        end
    end
    assign res_ok = cmd.res_code == iba_pkg::ST_OK;

    // status to controller
    always_comb
    begin
        stat.func_del   = func_reg;
        stat.n_over     = 32'(n_reg) > 32'(free_reg);
        stat.need_over  = (32'(n_reg) + 32'(has_ind_c)) > 32'(free_reg);
        stat.hit        = hit_reg;
        stat.free_found = ff_reg;
        stat.scan_done  = cmp_v_reg && (32'(cmp_idx_reg) == INODE_COUNT - 1);
        stat.alloc_done = alloc_done;
        stat.free_done  = (k_reg == total_reg) && !rd_v_reg;
        stat.out_busy   = out_v_reg && !out_tready;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg     <= BCW'(DISK_BLOCKS);
            used_reg     <= '0;
            valid_reg    <= '0;
            scan_cnt_reg <= '0;
            cmp_v_reg    <= 1'b0;
            hit_reg      <= 1'b0;
            ff_reg       <= 1'b0;
            rd_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            cmp_v_reg <= scan_issue;
            rd_v_reg  <= free_issue;
            if (cmd.scan_start)
            begin
                scan_cnt_reg <= '0;
                hit_reg      <= 1'b0;
                ff_reg       <= 1'b0;
            end
            else if (scan_issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + SW'(1);
            end
            if (cmp_v_reg && key_match && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (cmp_v_reg && !valid_reg[cmp_idx_reg] && !ff_reg)
            begin
                ff_reg <= 1'b1;
            end
            if (alloc_take)
            begin
                used_reg[b_idx] <= 1'b1;
            end
            if (rel_ok)
            begin
                used_reg[rel_blk] <= 1'b0;
            end
            if (cmd.commit_ins)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            if (cmd.commit_del)
            begin
                valid_reg[slot_reg] <= 1'b0;
            end
            if (cmd.res_write)
            begin
                free_reg  <= free_res;
                out_v_reg <= 1'b1;
            end
            else if (out_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            key_reg  <= in_key;
            n_reg    <= in_count;
        end
        if (cmd.size_lat)
        begin
            n_reg <= size_rd;
        end
        if (scan_issue)
        begin
            cmp_idx_reg <= scan_cnt_reg[IW-1:0];
        end
        if (cmp_v_reg && key_match && !hit_reg)
        begin
            hit_idx_reg <= cmp_idx_reg;
        end
        if (cmp_v_reg && !valid_reg[cmp_idx_reg] && !ff_reg)
        begin
            ff_idx_reg <= cmp_idx_reg;
        end
        if (cmd.pick)
        begin
            slot_reg <= func_reg ? hit_idx_reg : ff_idx_reg;
        end
        if (cmd.prep)
        begin
            ndir_reg      <= has_ind_c ? CW'(DIRECT_SLOTS) : CW'(n_reg);
            total_reg     <= CW'(n_reg) + CW'(has_ind_c);
            has_ind_reg   <= has_ind_c;
            k_reg         <= '0;
            cnt_reg       <= '0;
            b_reg         <= '0;
            dir_base_reg  <= DAW'(32'(slot_reg) * DIRECT_SLOTS);
            list_base_reg <= LAW'(32'(slot_reg) * DISK_BLOCKS);
        end
        if (cmd.alloc_step && !alloc_done)
        begin
            b_reg <= b_reg + BCW'(1);
        end
        if (alloc_take)
        begin
            k_reg   <= k_reg + CW'(1);
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (free_issue)
        begin
            k_reg   <= k_reg + CW'(1);
            src_reg <= k_src;
        end
        if (rel_ok)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.res_write)
        begin
            o_status_reg <= cmd.res_code;
            o_ino_reg    <= res_ok ? 5'(slot_reg) : 5'd0;
            o_chg_reg    <= res_ok ? 8'(cnt_reg) : 8'd0;
            o_free_reg   <= 8'(free_res);
        end
    end

    // inode key and size stores
    iba_ram #(.WIDTH(64), .DEPTH(INODE_COUNT)) u_key_ram (
        .clk   (clk),
        .we    (cmd.commit_ins),
        .waddr (slot_reg),
        .wdata (key_reg),
        .raddr (scan_cnt_reg[IW-1:0]),
        .rdata (key_rd)
    );

    iba_ram #(.WIDTH(8), .DEPTH(INODE_COUNT)) u_size_ram (
        .clk   (clk),
        .we    (cmd.commit_ins),
        .waddr (slot_reg),
        .wdata (n_reg),
        .raddr (slot_reg),
        .rdata (size_rd)
    );

    // block pointer stores
    iba_ram #(.WIDTH(BW), .DEPTH(INODE_COUNT * DIRECT_SLOTS)) u_dir_ram (
        .clk   (clk),
        .we    (alloc_take && (k_src == SRC_DIR)),
        .waddr (dir_addr),
        .wdata (b_idx),
        .raddr (dir_addr),
        .rdata (dir_rd)
    );

    iba_ram #(.WIDTH(BW), .DEPTH(INODE_COUNT)) u_ptr_ram (
        .clk   (clk),
        .we    (alloc_take && (k_src == SRC_PTR)),
        .waddr (slot_reg),
        .wdata (b_idx),
        .raddr (slot_reg),
        .rdata (ptr_rd)
    );

    iba_ram #(.WIDTH(BW), .DEPTH(INODE_COUNT * DISK_BLOCKS)) u_list_ram (
        .clk   (clk),
        .we    (alloc_take && (k_src == SRC_LIST)),
        .waddr (list_addr),
        .wdata (b_idx),
        .raddr (list_addr),
        .rdata (list_rd)
    );

    assign out_tvalid = out_v_reg;
    assign out_data   = {o_free_reg, o_chg_reg, o_ino_reg, o_status_reg};

endmodule

`default_nettype wire

[hdl/inode_block_allocator_unit.sv]
`default_nettype none

// Inode block allocator. Each input word is an insert (tuser 0) or a delete (tuser 1)
// of a file named by a 64-bit key; every word gives exactly one result word with
// status, inode, blocks changed and the free count. An insert checks the request
// against the free count, scans all inodes for the key and a free inode (one inode
// a cycle through the key memory), then walks the block map one block a cycle from
// block zero. A delete scans the same way and then reads one pointer a cycle from
// the pointer memories, one for each block of the file, counting its indirect block.
// One operation runs at a time; the result sits in an output register, so a new word
// is taken while the previous result waits.
module inode_block_allocator_unit #(
    parameter int DISK_BLOCKS  = iba_pkg::DISK_BLOCKS_DEF,
    parameter int INODE_COUNT  = iba_pkg::INODE_COUNT_DEF,
    parameter int DIRECT_SLOTS = iba_pkg::DIRECT_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // file_key[63:0], block_count[71:64]
    input  wire logic [0:0]  s_axis_tuser,  // func[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // status[2:0], inode_index[7:3],
                                            // blocks_changed[15:8], free_blocks[23:16]
);

    iba_pkg::cmd_t  cmd;
    iba_pkg::stat_t stat;

    // sequencing
    iba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // tables, counters and result register
    iba_dpath #(
        .DISK_BLOCKS  (DISK_BLOCKS),
        .INODE_COUNT  (INODE_COUNT),
        .DIRECT_SLOTS (DIRECT_SLOTS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (s_axis_tuser[0]),
        .in_key     (s_axis_tdata[63:0]),
        .in_count   (s_axis_tdata[71:64]),
        .out_tready (m_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire
